FILE: hdl/apcn_pkg.sv
// Shared types, constants and functions for the AABB pair collision notifier.
// Used by apcn_ctrl, apcn_datapath and aabb_pair_collision_notifier.
package apcn_pkg;

  localparam int unsigned MATRIX_W  = 36;
  localparam int unsigned IDX_OUT_W = 5;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 64;

  localparam logic [MATRIX_W-1:0] NOTIFY_RESET = 36'd34071064418;

  localparam logic       REG_NOTIFY  = 1'b0;
  localparam logic       FUNC_ADD    = 1'b0;
  localparam logic       FUNC_CLEAR  = 1'b1;
  localparam logic       KIND_NOTIFY = 1'b0;
  localparam logic       KIND_DROP   = 1'b1;
  localparam logic [2:0] TYPE_MAX    = 3'd5;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } rect_t;

  typedef struct packed {
    logic       listen;
    logic [2:0] ctype;
  } attr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load_add;
    logic load_full;
    logic clear;
    logic scan;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic scan_done;
    logic pend_vld;
    logic out_free;
  } status_t;

  // strict overlap, full precision
  function automatic logic overlap(rect_t a, rect_t b);
    logic signed [17:0] ax, ay, aw, ah, bx, by, bw, bh;
    ax = 18'(a.x);
    ay = 18'(a.y);
    bx = 18'(b.x);
    by = 18'(b.y);
    aw = {3'b000, a.w};
    ah = {3'b000, a.h};
    bw = {3'b000, b.w};
    bh = {3'b000, b.h};
    return (ax < bx + bw) && (ax + aw > bx) && (ay < by + bh) && (ay + ah > by);
  endfunction

  function automatic logic wants(attr_t recv, attr_t oth, logic [MATRIX_W-1:0] m);
    logic [5:0] bit_idx;
    bit_idx = 6'(recv.ctype) * 6'd6 + 6'(oth.ctype);
    return recv.listen && (recv.ctype <= TYPE_MAX) && (oth.ctype <= TYPE_MAX) &&
           m[bit_idx];
  endfunction

endpackage

FILE: hdl/aabb_pair_collision_notifier.sv
// A clear request empties the table when accepted; a full-table drop and an add
// end with a flush of the pending result. An add scans every stored collider, held
// per slot that notifies both sides and while the output stalls; the table memory is
// read one slot per cycle unless held. Results leave through an output register.
// Reset empties the table and loads notify_matrix with its default; the
// table memory itself is not cleared.
module aabb_pair_collision_notifier import apcn_pkg::*; #(
  parameter int unsigned MAX_COLLIDERS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 func_i,
  input  logic signed [15:0]   pos_x_i,
  input  logic signed [15:0]   pos_y_i,
  input  logic [14:0]          width_i,
  input  logic [14:0]          height_i,
  input  logic [2:0]           collider_type_i,
  input  logic                 has_listener_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 kind_o,
  output logic [IDX_OUT_W-1:0] receiver_index_o,
  output logic [IDX_OUT_W-1:0] other_index_o,
  output logic                 last_o
);

  logic [MATRIX_W-1:0] matrix_q;
  logic                sel_notify;
  cmd_t                cmd;
  status_t             status;

  assign pready     = 1'b1;
  assign sel_notify = (paddr[PADDR_W-1] == REG_NOTIFY);
  assign prdata     = sel_notify ? PDATA_W'(matrix_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_q <= NOTIFY_RESET;
    end else if (psel && penable && pwrite && pready && sel_notify) begin
      matrix_q <= pwdata[MATRIX_W-1:0];
    end
  end

  apcn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  apcn_datapath #(
    .MAX_COLLIDERS (MAX_COLLIDERS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .matrix_i         (matrix_q),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .width_i          (width_i),
    .height_i         (height_i),
    .collider_type_i  (collider_type_i),
    .has_listener_i   (has_listener_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .kind_o           (kind_o),
    .receiver_index_o (receiver_index_o),
    .other_index_o    (other_index_o),
    .last_o           (last_o)
  );

endmodule

FILE: hdl/apcn_ctrl.sv
// Controller state machine for the collision notifier: request intake,
// table scan sequencing and final flush. Depends on apcn_pkg.
module apcn_ctrl import apcn_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    func_i,
  input  status_t status_i,
  output logic    in_stall_o,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && func_i == FUNC_ADD) begin
          state_d = status_i.full ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!status_i.pend_vld || status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.clear     = accept && (func_i == FUNC_CLEAR);
    cmd_o.load_add  = accept && (func_i == FUNC_ADD) && !status_i.full;
    cmd_o.load_full = accept && (func_i == FUNC_ADD) && status_i.full;
    cmd_o.scan      = (state_q == ST_SCAN);
    cmd_o.fin       = (state_q == ST_FIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN && status_i.pend_vld && !status_i.out_free |=> state_q == ST_FIN)
    else $error("flush left with result still pending");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !status_i.pend_vld)
    else $error("pending result while idle");

  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE && in_valid_i && func_i == FUNC_CLEAR |=> state_q == ST_IDLE)
    else $error("clear request left idle");

endmodule

FILE: hdl/apcn_datapath.sv
// Datapath: collider table memory, read/compare pipeline, result pending
// stage and output register. Depends on apcn_pkg.
module apcn_datapath import apcn_pkg::*; #(
  parameter int unsigned MAX_COLLIDERS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic [MATRIX_W-1:0]   matrix_i,
  input  logic signed [15:0]    pos_x_i,
  input  logic signed [15:0]    pos_y_i,
  input  logic [14:0]           width_i,
  input  logic [14:0]           height_i,
  input  logic [2:0]            collider_type_i,
  input  logic                  has_listener_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic                  kind_o,
  output logic [IDX_OUT_W-1:0]  receiver_index_o,
  output logic [IDX_OUT_W-1:0]  other_index_o,
  output logic                  last_o
);

  localparam int unsigned IDX_W = $clog2(MAX_COLLIDERS);
  localparam int unsigned CNT_W = $clog2(MAX_COLLIDERS + 1);

  rect_t mem_rect [MAX_COLLIDERS];
  attr_t mem_attr [MAX_COLLIDERS];

  logic [CNT_W-1:0] count_q, idx_q;
  logic [IDX_W-1:0] n_q, s1_slot_q, s2_slot_q;
  rect_t            new_rect_q, rd_rect_q;
  attr_t            new_attr_q, rd_attr_q;
  logic             s1_vld_q, s2_vld_q;
  logic [1:0]       s2_hit_q;
  logic             pend_vld_q, pend_kind_q;
  logic [IDX_W-1:0] pend_recv_q, pend_oth_q;
  logic             out_vld_q, out_kind_q, out_last_q;
  logic [IDX_W-1:0] out_recv_q, out_oth_q;

  logic             issue, adv, take, busy, out_free, out_load, ov;
  logic [1:0]       s1_hit, hits_rem;
  logic [IDX_W-1:0] cand_recv, cand_oth;

  function automatic rect_t new_rect_d();
    rect_t r;
    r.x = pos_x_i;
    r.y = pos_y_i;
    r.w = width_i;
    r.h = height_i;
    return r;
  endfunction

  // bit 0: stored side notified, bit 1: new side notified
  assign ov     = overlap(rd_rect_q, new_rect_q);
  assign s1_hit = {ov && wants(new_attr_q, rd_attr_q, matrix_i),
                   ov && wants(rd_attr_q, new_attr_q, matrix_i)};

  assign out_free  = !out_vld_q || !out_stall_i;
  assign take      = cmd_i.scan && s2_vld_q && (s2_hit_q != 2'b00) &&
                     (!pend_vld_q || out_free);
  assign hits_rem  = take ? (s2_hit_q[0] ? {s2_hit_q[1], 1'b0} : 2'b00) : s2_hit_q;
  assign busy      = s2_vld_q && (hits_rem != 2'b00);
  assign adv       = cmd_i.scan && !busy;
  assign issue     = idx_q < CNT_W'(n_q);
  assign cand_recv = s2_hit_q[0] ? s2_slot_q : n_q;
  assign cand_oth  = s2_hit_q[0] ? n_q : s2_slot_q;
  assign out_load  = pend_vld_q && (take || (cmd_i.fin && out_free));

  assign status_o.full      = (count_q == CNT_W'(MAX_COLLIDERS));
  assign status_o.scan_done = !issue && !s1_vld_q && !busy;
  assign status_o.pend_vld  = pend_vld_q;
  assign status_o.out_free  = out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_add) begin
      mem_rect[count_q[IDX_W-1:0]] <= new_rect_d();
      mem_attr[count_q[IDX_W-1:0]] <= attr_t'({has_listener_i, collider_type_i});
    end
    if (adv && issue) begin
      rd_rect_q <= mem_rect[idx_q[IDX_W-1:0]];
      rd_attr_q <= mem_attr[idx_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      idx_q      <= '0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      s2_hit_q   <= 2'b00;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.load_add) begin
        count_q <= count_q + 1'b1;
        idx_q   <= '0;
      end
      if (adv) begin
        if (issue) idx_q <= idx_q + 1'b1;
        s1_vld_q <= issue;
        s2_vld_q <= s1_vld_q;
        s2_hit_q <= s1_hit;
      end else if (take) begin
        s2_hit_q <= hits_rem;
      end
      if (cmd_i.load_full || take) begin
        pend_vld_q <= 1'b1;
      end else if (cmd_i.fin && out_free) begin
        pend_vld_q <= 1'b0;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_free) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_add) begin
      new_rect_q <= new_rect_d();
      new_attr_q <= attr_t'({has_listener_i, collider_type_i});
      n_q        <= count_q[IDX_W-1:0];
    end
    if (adv && issue) s1_slot_q <= idx_q[IDX_W-1:0];
    if (adv) s2_slot_q <= s1_slot_q;
    if (take) begin
      pend_kind_q <= KIND_NOTIFY;
      pend_recv_q <= cand_recv;
      pend_oth_q  <= cand_oth;
    end else if (cmd_i.load_full) begin
      pend_kind_q <= KIND_DROP;
      pend_recv_q <= '0;
      pend_oth_q  <= '0;
    end
    if (out_load) begin
      out_kind_q <= pend_kind_q;
      out_recv_q <= pend_recv_q;
      out_oth_q  <= pend_oth_q;
      out_last_q <= cmd_i.fin;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign kind_o           = out_kind_q;
  assign receiver_index_o = IDX_OUT_W'(out_recv_q);
  assign other_index_o    = IDX_OUT_W'(out_oth_q);
  assign last_o           = out_last_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_COLLIDERS))
    else $error("entry count beyond table size");

  a_double_hit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q && s2_hit_q == 2'b11 |-> !adv)
    else $error("pipeline advanced with two hits outstanding");

  a_s1_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> cmd_i.scan)
    else $error("read stage busy outside scan");

endmodule

FILE: sim/tb_aabb_pair_collision_notifier.sv
// Testbench for aabb_pair_collision_notifier: a scoreboard keeps its own copy of the collider
// table and notify matrix and predicts every notification and drop, checked in order.
// Depends on apcn_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_aabb_pair_collision_notifier;
  import apcn_pkg::*;

  localparam int TABLE_DEPTH = 32;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic               func;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
    logic [2:0]         ctype;
    logic               listen;
  } request_t;

  typedef struct packed {
    logic                 kind;
    logic [IDX_OUT_W-1:0] recv;
    logic [IDX_OUT_W-1:0] other;
    logic                 last;
  } note_t;

  class collision_scoreboard;
    logic [MATRIX_W-1:0] matrix;
    rect_t               rects[TABLE_DEPTH];
    attr_t               attrs[TABLE_DEPTH];
    int unsigned         count;
    note_t               pending[$];
    int                  errors;

    function new();
      matrix = NOTIFY_RESET;
      count  = 0;
      errors = 0;
    endfunction

    function bit notifies(attr_t r, attr_t o);
      if (!r.listen || r.ctype > TYPE_MAX || o.ctype > TYPE_MAX) return 1'b0;
      return matrix[int'(r.ctype) * 6 + int'(o.ctype)];
    endfunction

    function void note_request(request_t rq);
      rect_t nr;
      attr_t na;
      int    ax, ay, aw, ah, bx, by, bw, bh;
      int    k;
      if (rq.func == FUNC_CLEAR) begin
        count = 0;
        return;
      end
      if (count >= TABLE_DEPTH) begin
        pending.push_back('{KIND_DROP, '0, '0, 1'b1});
        return;
      end
      nr.x = rq.x;
      nr.y = rq.y;
      nr.w = rq.w;
      nr.h = rq.h;
      na.ctype  = rq.ctype;
      na.listen = rq.listen;
      bx = $signed(nr.x);
      by = $signed(nr.y);
      bw = int'(nr.w);
      bh = int'(nr.h);
      k = 0;
      for (int i = 0; i < count; i++) begin
        ax = $signed(rects[i].x);
        ay = $signed(rects[i].y);
        aw = int'(rects[i].w);
        ah = int'(rects[i].h);
        if (!(ax < bx + bw && ax + aw > bx && ay < by + bh && ay + ah > by)) continue;
        if (notifies(attrs[i], na)) begin
          pending.push_back('{KIND_NOTIFY, IDX_OUT_W'(i), IDX_OUT_W'(count), 1'b0});
          k++;
        end
        if (notifies(na, attrs[i])) begin
          pending.push_back('{KIND_NOTIFY, IDX_OUT_W'(count), IDX_OUT_W'(i), 1'b0});
          k++;
        end
      end
      if (k > 0) pending[pending.size()-1].last = 1'b1;
      rects[count] = nr;
      attrs[count] = na;
      count++;
    endfunction

    function void check_result(note_t got);
      note_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d recv %0d other %0d last %0d",
                 $time, got.kind, got.recv, got.other, got.last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind || got.recv !== want.recv ||
          got.other !== want.other || got.last !== want.last) begin
        $display("%0t: result differs: expected kind %0d recv %0d other %0d last %0d",
                 $time, want.kind, want.recv, want.other, want.last);
        $display("%0t:                 actual   kind %0d recv %0d other %0d last %0d",
                 $time, got.kind, got.recv, got.other, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 psel, penable, pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 func_i;
  logic signed [15:0]   pos_x_i, pos_y_i;
  logic [14:0]          width_i, height_i;
  logic [2:0]           collider_type_i;
  logic                 has_listener_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 kind_o;
  logic [IDX_OUT_W-1:0] receiver_index_o, other_index_o;
  logic                 last_o;

  collision_scoreboard sb;
  bit quiet;
  int idle_pct;
  int stall_pct;
  int sent;

  aabb_pair_collision_notifier dut (.*);

  always #2 clk_i = ~clk_i;

  initial begin
    #10_000_000;
    $display("aabb_pair_collision_notifier: mismatch");
    $finish;
  end

  // receive side: check accepted results, stall in random bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        sb.check_result('{kind_o, receiver_index_o, other_index_o, last_o});
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 17);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_request(input request_t rq);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= rq.func;
    pos_x_i         <= rq.x;
    pos_y_i         <= rq.y;
    width_i         <= rq.w;
    height_i        <= rq.h;
    collider_type_i <= rq.ctype;
    has_listener_i  <= rq.listen;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(rq);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_notify_matrix(input logic [MATRIX_W-1:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({REG_NOTIFY, 3'b000});
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.matrix = value;
  endtask

  function automatic request_t add_req(int x, int y, int w, int h, int t, int l);
    request_t rq;
    rq.func   = FUNC_ADD;
    rq.x      = 16'(x);
    rq.y      = 16'(y);
    rq.w      = 15'(w);
    rq.h      = 15'(h);
    rq.ctype  = 3'(t);
    rq.listen = 1'(l);
    return rq;
  endfunction

  function automatic request_t clear_req();
    request_t rq;
    rq = request_t'({$urandom, $urandom, $urandom});
    rq.func = FUNC_CLEAR;
    return rq;
  endfunction

  function automatic request_t random_add(logic [15:0] cx, logic [15:0] cy);
    request_t rq;
    int pick;
    pick = $urandom_range(0, 9);
    rq.func = FUNC_ADD;
    if (pick < 7) begin
      rq.x = 16'(cx + 16'($urandom_range(0, 63)));
      rq.y = 16'(cy + 16'($urandom_range(0, 63)));
      rq.w = 15'($urandom_range(0, 48));
      rq.h = 15'($urandom_range(0, 48));
    end else if (pick < 9) begin
      rq.x = 16'($urandom);
      rq.y = 16'($urandom);
      rq.w = 15'($urandom);
      rq.h = 15'($urandom);
    end else begin
      rq.x = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
      rq.y = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
      rq.w = $urandom_range(0, 1) ? 15'h7FFF : 15'($urandom_range(0, 3));
      rq.h = $urandom_range(0, 1) ? 15'h7FFF : 15'($urandom_range(0, 3));
    end
    rq.ctype  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                            : 3'($urandom_range(0, 5));
    rq.listen = ($urandom_range(0, 3) != 0);
    return rq;
  endfunction

  initial begin
    int pcts[4];
    int target, len;
    bit long_next;
    logic [15:0] cx, cy;
    logic [MATRIX_W-1:0] settings[5];

    pcts = '{0, 10, 30, 60};
    sb = new();
    quiet     = 1'b0;
    idle_pct  = 20;
    stall_pct = 20;
    sent      = 0;
    rst_ni          = 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_valid_i      <= 1'b0;
    func_i          <= FUNC_ADD;
    pos_x_i         <= '0;
    pos_y_i         <= '0;
    width_i         <= '0;
    height_i        <= '0;
    collider_type_i <= '0;
    has_listener_i  <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: overlaps, abutting edges, empty rects, odd types, extremes
    send_request(clear_req());
    send_request(add_req(0, 0, 10, 10, 1, 1));
    send_request(add_req(5, 5, 10, 10, 4, 1));
    send_request(add_req(10, 0, 5, 5, 5, 1));
    send_request(add_req(2, 2, 0, 8, 3, 1));
    send_request(add_req(2, 2, 8, 0, 2, 1));
    send_request(add_req(3, 3, 4, 4, 6, 1));
    send_request(add_req(4, 4, 4, 4, 7, 1));
    send_request(add_req(6, 6, 3, 3, 5, 0));
    send_request(add_req(7, 7, 2, 2, 0, 1));
    send_request(add_req(-32768, -32768, 32767, 32767, 5, 1));
    send_request(add_req(-32768, -32768, 32767, 32767, 1, 1));
    send_request(add_req(32767, 32767, 32767, 32767, 4, 1));
    send_request(add_req(32000, 32000, 800, 800, 1, 1));
    send_request(add_req(-1, -1, 2, 2, 3, 1));
    send_request(clear_req());
    send_request(add_req(0, 0, 1, 1, 2, 0));
    send_request(add_req(0, 0, 1, 1, 2, 1));
    send_request(add_req(0, 0, 1, 1, 3, 1));

    settings[0] = '1;
    settings[1] = MATRIX_W'({$urandom, $urandom});
    settings[2] = '0;
    settings[3] = NOTIFY_RESET;
    settings[4] = MATRIX_W'({$urandom, $urandom});
    long_next = 1'b1;

    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) write_notify_matrix(settings[phase-1]);
      if (phase == 5) quiet = 1'b1;
      target = sent + 68;
      while (sent < target) begin
        idle_pct  = pcts[$urandom_range(0, 3)];
        stall_pct = pcts[$urandom_range(0, 3)];
        if (long_next || $urandom_range(0, 9) != 0) send_request(clear_req());
        if (long_next) len = 36;
        else if ($urandom_range(0, 4) == 0) len = $urandom_range(20, 36);
        else len = $urandom_range(1, 12);
        long_next = 1'b0;
        cx = 16'($urandom);
        cy = 16'($urandom);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 39) == 0) send_request(clear_req());
          send_request(random_add(cx, cy));
        end
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("aabb_pair_collision_notifier: match");
    end else begin
      $display("aabb_pair_collision_notifier: mismatch");
    end
    $finish;
  end

endmodule
